FILE: rtl/modbus_rtu_request_deframer_unit_macros.svh
// Assertion macros shared by the deframer checker.
`ifndef MODBUS_RTU_REQUEST_DEFRAMER_UNIT_MACROS_SVH
`define MODBUS_RTU_REQUEST_DEFRAMER_UNIT_MACROS_SVH

// Implication in the same cycle, switched off while reset is high.
`define MBRD_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle, switched off while reset is high.
`define MBRD_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// Implication in the next cycle, checked during reset as well.
`define MBRD_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/mbrd_pkg.sv
// Types, constants and the CRC step shared by the Modbus RTU request deframer.
package mbrd_pkg;

  localparam logic [7:0]  FUNC_MULTI_WRITE = 8'h10;
  localparam logic [15:0] SILENCE_DEFAULT  = 16'd40;
  localparam logic [15:0] GAP_MAX          = 16'hFFFF;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;
  localparam logic [8:0]  POS_MAX          = 9'd511;

  localparam logic OP_BYTE   = 1'b0;
  localparam logic OP_TICK   = 1'b1;
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  typedef struct packed {
    logic       operation;
    logic [7:0] rx_byte;
  } req_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [15:0] word_count;
    logic [7:0]  byte_count;
    logic [6:0]  data_index;
    logic [15:0] data_word;
    logic        crc_ok;
    logic [15:0] crc_error_count;
  } rsp_t;

  // One byte through the reflected Modbus CRC-16.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/mbrd_if.sv
// Channel interfaces for requests, results and the configuration write.
interface mbrd_req_if;
  logic          valid;
  logic          ready;
  mbrd_pkg::req_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mbrd_rsp_if;
  logic          valid;
  logic          ready;
  mbrd_pkg::rsp_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface mbrd_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/mbrd_in_stage.sv
// Input register that holds one accepted request until it is decoded.
module mbrd_in_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  input  mbrd_pkg::req_t in_payload,
  output logic           in_ready,
  input  logic           advance,
  output logic           full,
  output mbrd_pkg::req_t payload
);

  assign in_ready = !full || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      payload <= in_payload;
    end
  end

endmodule

FILE: rtl/mbrd_frame_core.sv
// Frame state, running CRC and result formation for one byte or tick per cycle while item_valid is high.
module mbrd_frame_core (
  input  logic           clk,
  input  logic           rst,
  input  logic [15:0]    silence_ticks,
  input  logic           item_valid,
  input  mbrd_pkg::req_t item,
  output logic           result_valid,
  output mbrd_pkg::rsp_t result
);

  logic [15:0] gap_count, gap_count_next;
  logic [8:0]  byte_position, byte_position_next;
  logic [7:0]  frame_slave, frame_slave_next;
  logic [7:0]  frame_function, frame_function_next;
  logic [7:0]  high_byte_latch, high_byte_latch_next;
  logic [15:0] frame_start, frame_start_next;
  logic [15:0] frame_count_field, frame_count_field_next;
  logic [7:0]  frame_byte_count, frame_byte_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [7:0]  received_crc_low, received_crc_low_next;
  logic [15:0] bad_frame_count, bad_frame_count_next;

  logic        gap_hit;
  logic [8:0]  pos;
  logic [9:0]  pos_ext;
  logic [9:0]  bc_ext;
  logic [8:0]  data_offset;
  logic [15:0] crc_base;
  logic [15:0] crc_fed;
  logic        crc_match;
  logic [7:0]  b;
  logic        emit_data;
  logic        emit_end;

  always_comb begin
    b           = item.rx_byte;
    gap_hit     = (gap_count == mbrd_pkg::GAP_MAX) || (gap_count > silence_ticks);
    pos         = gap_hit ? 9'd0 : byte_position;
    pos_ext     = {1'b0, pos};
    bc_ext      = {2'b00, frame_byte_count};
    data_offset = pos - 9'd7;
    crc_base    = (pos == 9'd0) ? mbrd_pkg::CRC_INIT : running_crc;
    crc_fed     = mbrd_pkg::crc_feed(crc_base, b);
    crc_match   = (received_crc_low == running_crc[7:0]) && (b == running_crc[15:8]);

    gap_count_next         = gap_count;
    byte_position_next     = byte_position;
    frame_slave_next       = frame_slave;
    frame_function_next    = frame_function;
    high_byte_latch_next   = high_byte_latch;
    frame_start_next       = frame_start;
    frame_count_field_next = frame_count_field;
    frame_byte_count_next  = frame_byte_count;
    running_crc_next       = running_crc;
    received_crc_low_next  = received_crc_low;
    bad_frame_count_next   = bad_frame_count;
    emit_data              = 1'b0;
    emit_end               = 1'b0;

    if (item.operation == mbrd_pkg::OP_TICK) begin
      if (gap_count != mbrd_pkg::GAP_MAX) begin
        gap_count_next = gap_count + 16'd1;
      end
    end else begin
      gap_count_next = 16'd0;
      if (pos == 9'd0) begin
        frame_slave_next = b;
        running_crc_next = crc_fed;
      end else if (pos <= 9'd5) begin
        case (pos)
          9'd1:        frame_function_next    = b;
          9'd2, 9'd4:  high_byte_latch_next   = b;
          9'd3:        frame_start_next       = {high_byte_latch, b};
          default:     frame_count_field_next = {high_byte_latch, b};
        endcase
        running_crc_next = crc_fed;
      end else if (frame_function != mbrd_pkg::FUNC_MULTI_WRITE) begin
        if (pos == 9'd6) begin
          received_crc_low_next = b;
        end else if (pos == 9'd7) begin
          emit_end = 1'b1;
        end
      end else begin
        if (pos == 9'd6) begin
          frame_byte_count_next = b;
          running_crc_next      = crc_fed;
        end else if (pos_ext <= bc_ext + 10'd6) begin
          running_crc_next = crc_fed;
          if (!data_offset[0]) begin
            high_byte_latch_next = b;
          end else begin
            emit_data = 1'b1;
          end
        end else if (pos_ext == bc_ext + 10'd7) begin
          received_crc_low_next = b;
        end else if (pos_ext == bc_ext + 10'd8) begin
          emit_end = 1'b1;
        end
      end
      if (emit_end && !crc_match) begin
        bad_frame_count_next = bad_frame_count + 16'd1;
      end
      byte_position_next = (pos < mbrd_pkg::POS_MAX) ? pos + 9'd1 : pos;
    end
  end

  always_comb begin
    result_valid           = item_valid && (emit_data || emit_end);
    result.kind            = emit_end ? mbrd_pkg::KIND_END : mbrd_pkg::KIND_DATA;
    result.slave_address   = frame_slave;
    result.function_code   = frame_function;
    result.start_address   = frame_start;
    result.word_count      = frame_count_field;
    result.byte_count      = (frame_function == mbrd_pkg::FUNC_MULTI_WRITE) ?
                             frame_byte_count : 8'd0;
    result.data_index      = emit_data ? data_offset[7:1] : 7'd0;
    result.data_word       = emit_data ? {high_byte_latch, b} : 16'd0;
    result.crc_ok          = emit_end && crc_match;
    result.crc_error_count = bad_frame_count_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gap_count         <= mbrd_pkg::GAP_MAX;
      byte_position     <= 9'd0;
      frame_slave       <= 8'd1;
      frame_function    <= 8'd0;
      high_byte_latch   <= 8'd0;
      frame_start       <= 16'd0;
      frame_count_field <= 16'd0;
      frame_byte_count  <= 8'd0;
      running_crc       <= mbrd_pkg::CRC_INIT;
      received_crc_low  <= 8'd0;
      bad_frame_count   <= 16'd0;
    end else if (item_valid) begin
      gap_count         <= gap_count_next;
      byte_position     <= byte_position_next;
      frame_slave       <= frame_slave_next;
      frame_function    <= frame_function_next;
      high_byte_latch   <= high_byte_latch_next;
      frame_start       <= frame_start_next;
      frame_count_field <= frame_count_field_next;
      frame_byte_count  <= frame_byte_count_next;
      running_crc       <= running_crc_next;
      received_crc_low  <= received_crc_low_next;
      bad_frame_count   <= bad_frame_count_next;
    end
  end

endmodule

FILE: rtl/mbrd_out_stage.sv
// Result register that holds one result until the receiver takes it.
module mbrd_out_stage (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  logic           load_valid,
  input  mbrd_pkg::rsp_t load_payload,
  output logic           valid,
  input  logic           ready,
  output mbrd_pkg::rsp_t payload
);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= load_valid;
    end else if (ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) begin
      payload <= load_payload;
    end
  end

endmodule

FILE: rtl/modbus_rtu_request_deframer_unit.sv
// Top level of the Modbus RTU request deframer.
// Requests arrive on req: operation 0 carries one received byte in rx_byte,
// operation 1 is one time tick. Ticks count line silence; a byte after more
// than silence_ticks ticks (or after an idle line) starts a new frame.
// Results leave on rsp: a data word for each completed word of a multiple
// write, and a frame-end result with crc_ok and the bad frame count.
// The cfg channel writes silence_ticks; it is always ready. It is to be written
// only while the block is idle; the block itself does not enforce this.
// A request is taken into an input register and decoded from there; its
// result, if any, is loaded into the result register and valid on rsp. The CRC
// byte step and the frame decode sit between those two registers, so one
// request is accepted every cycle while rsp is not stalled.
// Reset clears the frame state, sets silence_ticks to 40 and marks the line
// idle. When rsp stalls, the held result waits and one more request is taken
// into the input register; req.ready then drops until rsp is taken.
module modbus_rtu_request_deframer_unit (
  input logic       clk,
  input logic       rst,
  mbrd_req_if.sink  req,
  mbrd_rsp_if.source rsp,
  mbrd_cfg_if.sink  cfg
);

  logic           stage_full;
  mbrd_pkg::req_t stage_payload;
  logic           advance;
  logic           core_valid;
  mbrd_pkg::rsp_t core_result;
  logic [15:0]    silence_ticks;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      silence_ticks <= mbrd_pkg::SILENCE_DEFAULT;
    end else if (cfg.valid) begin
      silence_ticks <= cfg.data;
    end
  end

  assign advance = stage_full && (!rsp.valid || rsp.ready);

  mbrd_in_stage u_in_stage (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (req.valid),
    .in_payload (req.payload),
    .in_ready   (req.ready),
    .advance    (advance),
    .full       (stage_full),
    .payload    (stage_payload)
  );

  mbrd_frame_core u_frame_core (
    .clk           (clk),
    .rst           (rst),
    .silence_ticks (silence_ticks),
    .item_valid    (advance),
    .item          (stage_payload),
    .result_valid  (core_valid),
    .result        (core_result)
  );

  mbrd_out_stage u_out_stage (
    .clk          (clk),
    .rst          (rst),
    .load         (advance),
    .load_valid   (core_valid),
    .load_payload (core_result),
    .valid        (rsp.valid),
    .ready        (rsp.ready),
    .payload      (rsp.payload)
  );

endmodule

FILE: rtl/mbrd_checker.sv
// Port-level checker for the deframer and its bind to the top level.
`include "modbus_rtu_request_deframer_unit_macros.svh"

module mbrd_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input mbrd_pkg::rsp_t rsp_payload
);

  // A stalled result keeps its value until taken.
  `MBRD_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_payload))

  // With no result waiting, the decode stage is free to drain, so requests are taken.
  `MBRD_ASSERT_IMP(a_req_ready_when_empty, clk, rst, !rsp_valid, req_ready)

  // Reset leaves no result pending.
  `MBRD_ASSERT_NEXT_ALWAYS(a_reset_clears, clk, rst, !rsp_valid)

endmodule

bind modbus_rtu_request_deframer_unit mbrd_checker u_mbrd_checker (
  .clk         (clk),
  .rst         (rst),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .rsp_payload (rsp.payload)
);

FILE: tb/testbench.sv
// Self-checking testbench for the Modbus RTU request deframer.
`timescale 1ns / 1ps

module testbench;

  localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int PIPE_SETTLE = 8;
  localparam int PHASE_ITEMS = 250;
  localparam int NUM_PHASES = 7;

  typedef enum {FAULT_NONE, FAULT_CRC, FAULT_TRUNCATE, FAULT_TRAILING} frame_fault_t;

  // Tracks the deframer state and holds the results still owed by the block.
  class deframe_checker_t;
    logic [15:0] silence;
    logic [15:0] gap;
    logic [8:0]  pos;
    logic [7:0]  slave;
    logic [7:0]  func;
    logic [7:0]  hi_latch;
    logic [15:0] start_addr;
    logic [15:0] count_field;
    logic [7:0]  byte_cnt;
    logic [15:0] crc;
    logic [7:0]  crc_lo_rx;
    logic [15:0] bad_frames;
    mbrd_pkg::rsp_t due_results[$];
    int          failures;

    function new();
      silence = mbrd_pkg::SILENCE_DEFAULT;
      gap = mbrd_pkg::GAP_MAX;
      pos = '0;
      slave = 8'h01;
      func = '0;
      hi_latch = '0;
      start_addr = '0;
      count_field = '0;
      byte_cnt = '0;
      crc = mbrd_pkg::CRC_INIT;
      crc_lo_rx = '0;
      bad_frames = '0;
      failures = 0;
    endfunction

    static function logic [15:0] crc16_byte(logic [15:0] c, logic [7:0] b);
      logic fb;
      for (int k = 0; k < 8; k++) begin
        fb = c[0] ^ b[k];
        c = {1'b0, c[15:1]};
        if (fb) c = c ^ mbrd_pkg::CRC_POLY;
      end
      return c;
    endfunction

    function void set_silence(logic [15:0] v);
      silence = v;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    function mbrd_pkg::rsp_t header(logic kind);
      mbrd_pkg::rsp_t e;
      e = '0;
      e.kind = kind;
      e.slave_address = slave;
      e.function_code = func;
      e.start_address = start_addr;
      e.word_count = count_field;
      e.byte_count = (func == mbrd_pkg::FUNC_MULTI_WRITE) ? byte_cnt : 8'h00;
      e.crc_error_count = bad_frames;
      return e;
    endfunction

    function mbrd_pkg::rsp_t frame_end(logic [7:0] b);
      mbrd_pkg::rsp_t e;
      logic ok;
      ok = (crc_lo_rx == crc[7:0]) && (b == crc[15:8]);
      if (!ok) bad_frames = bad_frames + 1'b1;
      e = header(mbrd_pkg::KIND_END);
      e.crc_ok = ok;
      return e;
    endfunction

    function void decode_request(mbrd_pkg::req_t r);
      int p;
      int bc;
      logic [7:0] b;
      mbrd_pkg::rsp_t e;
      bit produced;
      produced = 0;
      b = r.rx_byte;
      if (r.operation == mbrd_pkg::OP_TICK) begin
        if (gap != mbrd_pkg::GAP_MAX) gap = gap + 1'b1;
        return;
      end
      // A saturated counter means an idle line, which always opens a frame.
      if (gap == mbrd_pkg::GAP_MAX || gap > silence) pos = '0;
      gap = '0;
      p = pos;
      bc = byte_cnt;
      if (p == 0) begin
        slave = b;
        crc = crc16_byte(mbrd_pkg::CRC_INIT, b);
      end else if (p <= 5) begin
        case (p)
          1: func = b;
          2, 4: hi_latch = b;
          3: start_addr = {hi_latch, b};
          default: count_field = {hi_latch, b};
        endcase
        crc = crc16_byte(crc, b);
      end else if (func != mbrd_pkg::FUNC_MULTI_WRITE) begin
        if (p == 6) begin
          crc_lo_rx = b;
        end else if (p == 7) begin
          e = frame_end(b);
          produced = 1;
        end
      end else if (p == 6) begin
        byte_cnt = b;
        crc = crc16_byte(crc, b);
      end else if (p <= bc + 6) begin
        crc = crc16_byte(crc, b);
        if (((p - 7) & 1) == 0) begin
          hi_latch = b;
        end else begin
          e = header(mbrd_pkg::KIND_DATA);
          e.data_index = 7'((p - 7) >> 1);
          e.data_word = {hi_latch, b};
          produced = 1;
        end
      end else if (p == bc + 7) begin
        crc_lo_rx = b;
      end else if (p == bc + 8) begin
        e = frame_end(b);
        produced = 1;
      end
      if (pos != mbrd_pkg::POS_MAX) pos = pos + 1'b1;
      if (produced) due_results.push_back(e);
    endfunction

    function void compare_field(string field, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
        failures++;
      end
    endfunction

    function void check_result(mbrd_pkg::rsp_t got);
      mbrd_pkg::rsp_t want;
      if (due_results.size() == 0) begin
        $error("result with nothing expected: 0x%0h", got);
        failures++;
        return;
      end
      want = due_results.pop_front();
      compare_field("kind", 16'(want.kind), 16'(got.kind));
      compare_field("slave_address", 16'(want.slave_address), 16'(got.slave_address));
      compare_field("function_code", 16'(want.function_code), 16'(got.function_code));
      compare_field("start_address", want.start_address, got.start_address);
      compare_field("word_count", want.word_count, got.word_count);
      compare_field("byte_count", 16'(want.byte_count), 16'(got.byte_count));
      compare_field("data_index", 16'(want.data_index), 16'(got.data_index));
      compare_field("data_word", want.data_word, got.data_word);
      compare_field("crc_ok", 16'(want.crc_ok), 16'(got.crc_ok));
      compare_field("crc_error_count", want.crc_error_count, got.crc_error_count);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  mbrd_req_if req();
  mbrd_rsp_if rsp();
  mbrd_cfg_if cfg();

  modbus_rtu_request_deframer_unit DUT (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp),
    .cfg (cfg)
  );

  deframe_checker_t sb = new();

  int silence_setting = mbrd_pkg::SILENCE_DEFAULT;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int sent_items = 0;
  int cycle_count = 0;

  int phase_silence [NUM_PHASES] = '{0, 1, 2, 40, -1, 7, -1};
  int phase_idle [NUM_PHASES] = '{0, 55, 0, 29, 55, 0, 29};
  int phase_stall [NUM_PHASES] = '{0, 0, 55, 29, 0, 55, 29};

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    rsp.ready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) sb.decode_request(req.payload);
      if (rsp.valid && rsp.ready) sb.check_result(rsp.payload);
    end
  end

  task automatic send_request(input logic op, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      req.valid <= 1'b0;
      @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= '{operation: op, rx_byte: b};
    do @(posedge clk); while (!req.ready);
    sent_items++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_request(mbrd_pkg::OP_TICK, 8'($urandom));
  endtask

  // Enough silence that the next byte opens a frame; past the top this saturates.
  task automatic send_gap();
    if (silence_setting > 65530) send_ticks(65535 + $urandom_range(2));
    else send_ticks(silence_setting + 1 + $urandom_range(3));
  endtask

  task automatic send_frame_bytes(input logic [7:0] fb[$], input bit allow_ticks);
    int cap;
    cap = (silence_setting < 4) ? silence_setting : 4;
    foreach (fb[i]) begin
      // Short pauses inside a frame stay within the silence limit.
      if (i > 0 && allow_ticks && cap > 0 && $urandom_range(99) < 8)
        send_ticks($urandom_range(cap, 1));
      send_request(mbrd_pkg::OP_BYTE, fb[i]);
    end
  endtask

  function automatic logic [15:0] frame_crc(input logic [7:0] fb[$]);
    logic [15:0] c;
    c = mbrd_pkg::CRC_INIT;
    foreach (fb[i]) c = deframe_checker_t::crc16_byte(c, fb[i]);
    return c;
  endfunction

  task automatic send_fixed_frame(input logic [7:0] fb[$], input bit spoil);
    logic [15:0] c;
    c = frame_crc(fb);
    if (spoil) c = c ^ 16'h0100;
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    send_frame_bytes(fb, 1'b0);
  endtask

  task automatic send_frame(input logic [7:0] fn, input int data_len,
                            input frame_fault_t fault, input bit with_gap);
    logic [7:0] fb[$];
    logic [15:0] c;
    int k;
    fb.push_back(8'($urandom));
    fb.push_back(fn);
    repeat (4) fb.push_back(8'($urandom));
    if (fn == mbrd_pkg::FUNC_MULTI_WRITE) begin
      fb.push_back(8'(data_len));
      repeat (data_len) fb.push_back(8'($urandom));
    end
    c = frame_crc(fb);
    fb.push_back(c[7:0]);
    fb.push_back(c[15:8]);
    case (fault)
      FAULT_CRC: begin
        k = $urandom_range(fb.size() - 1, fb.size() - 2);
        fb[k] = fb[k] ^ (8'h01 << $urandom_range(7));
      end
      FAULT_TRUNCATE: begin
        repeat ($urandom_range(fb.size() - 1, 1)) void'(fb.pop_back());
      end
      FAULT_TRAILING: begin
        repeat ($urandom_range(4, 1)) fb.push_back(8'($urandom));
      end
      default: ;
    endcase
    if (with_gap) send_gap();
    send_frame_bytes(fb, 1'b1);
  endtask

  function automatic logic [7:0] pick_function();
    int r;
    r = $urandom_range(99);
    if (r < 50) return mbrd_pkg::FUNC_MULTI_WRITE;
    if (r < 70) return FUNC_READ_HOLDING;
    if (r < 85) return FUNC_WRITE_SINGLE;
    return 8'($urandom);
  endfunction

  // Mostly short multiple writes; a few long ones reach the top data indexes.
  function automatic int pick_data_len();
    int r;
    r = $urandom_range(99);
    if (r < 10) return 0;
    if (r < 80) return $urandom_range(16, 1);
    if (r < 95) return $urandom_range(64, 17);
    return $urandom_range(255, 65);
  endfunction

  function automatic frame_fault_t pick_fault();
    int r;
    r = $urandom_range(99);
    if (r < 70) return FAULT_NONE;
    if (r < 82) return FAULT_CRC;
    if (r < 92) return FAULT_TRUNCATE;
    return FAULT_TRAILING;
  endfunction

  // Stops sending and lets every owed result, and anything still in the pipe, drain.
  task automatic wait_drained();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (PIPE_SETTLE) @(posedge clk);
  endtask

  task automatic write_silence(input logic [15:0] v);
    wait_drained();
    cfg.valid <= 1'b1;
    cfg.data <= v;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.set_silence(v);
    silence_setting = v;
  endtask

  task automatic run_random_phase(input int budget);
    int phase_end;
    int r;
    phase_end = sent_items + budget;
    while (sent_items < phase_end) begin
      r = $urandom_range(99);
      if (r < 10) begin
        repeat ($urandom_range(10, 1)) begin
          if ($urandom_range(1)) send_request(mbrd_pkg::OP_TICK, 8'($urandom));
          else send_request(mbrd_pkg::OP_BYTE, 8'($urandom));
        end
      end else if (r < 12) begin
        wait_drained();
      end else if (r < 17) begin
        // No gap is sent before it, so unless earlier ticks opened a frame, it runs on from the last one.
        send_frame(pick_function(), pick_data_len(), pick_fault(), 1'b0);
      end else begin
        send_frame(pick_function(), pick_data_len(), pick_fault(), 1'b1);
      end
    end
  endtask

  initial begin
    logic [7:0] fixed_q[$];
    rst = 1'b1;
    req.valid = 1'b0;
    req.payload = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // The line starts idle, so the first byte opens a frame even with the
    // largest silence limit; unknown function code.
    write_silence(16'hFFFF);
    fixed_q = {8'h00, 8'h7F, 8'hFF, 8'hFF, 8'h00, 8'h00};
    send_fixed_frame(fixed_q, 1'b0);

    // With a zero silence limit a single tick separates frames.
    write_silence(16'd0);
    send_request(mbrd_pkg::OP_TICK, 8'hFF);
    fixed_q = {8'hFF, mbrd_pkg::FUNC_MULTI_WRITE, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h01, 8'hA5};
    send_fixed_frame(fixed_q, 1'b1);
    send_request(mbrd_pkg::OP_BYTE, 8'h5A);
    send_request(mbrd_pkg::OP_TICK, 8'h00);
    fixed_q = {8'h11, mbrd_pkg::FUNC_MULTI_WRITE, 8'h12, 8'h34, 8'h00, 8'h00, 8'h00};
    send_fixed_frame(fixed_q, 1'b0);

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      if (phase_silence[ph] < 0) write_silence(16'($urandom_range(30, 3)));
      else write_silence(16'(phase_silence[ph]));
      send_idle_pct = phase_idle[ph];
      stall_pct = phase_stall[ph];
      run_random_phase(PHASE_ITEMS);
    end

    // Largest silence limit: short silences never open a frame, so these run on.
    write_silence(16'hFFFF);
    send_idle_pct = 0;
    stall_pct = 0;
    send_frame(FUNC_READ_HOLDING, 0, FAULT_NONE, 1'b0);
    send_ticks(60);
    send_frame(mbrd_pkg::FUNC_MULTI_WRITE, 4, FAULT_NONE, 1'b0);

    wait_drained();
    if (sb.failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
